### rtl/core/mbts_pkg.sv
// Package for the Modbus TCP register server: field widths, opcode, kind and
// function codes, frame offsets and table sizes.
// No dependencies.
package mbts_pkg;

  localparam int HOLDING_REGS = 64;
  localparam int INPUT_REGS   = 64;
  localparam int FRAME_BYTES  = 64;
  localparam int MAX_WORDS    = 27;

  localparam int OPCODE_W = 2;
  localparam int BYTE_W   = 8;
  localparam int INDEX_W  = 6;
  localparam int VALUE_W  = 16;
  localparam int KIND_W   = 2;

  localparam int FS_AW = $clog2(FRAME_BYTES);
  localparam int FC_W  = $clog2(FRAME_BYTES + 1);
  localparam int H_AW  = $clog2(HOLDING_REGS);
  localparam int I_AW  = $clog2(INPUT_REGS);
  localparam int CNT_W = $clog2(MAX_WORDS + 1);

  localparam logic [OPCODE_W-1:0] OP_FRAME_BYTE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_SET_INPUT  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_SET_HOLD   = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_READ_HOLD  = 2'd3;

  localparam logic [KIND_W-1:0] KIND_REPLY  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

  localparam logic [BYTE_W-1:0] FN_READ_HOLD   = 8'd3;
  localparam logic [BYTE_W-1:0] FN_READ_INPUT  = 8'd4;
  localparam logic [BYTE_W-1:0] FN_WRITE_ONE   = 8'd6;
  localparam logic [BYTE_W-1:0] FN_WRITE_MULTI = 8'd16;

  // byte offsets in the request frame
  localparam int POS_LEN       = 5;
  localparam int POS_FN        = 7;
  localparam int POS_START     = 8;
  localparam int POS_HDR_LAST  = 11;
  localparam int POS_DATA      = 13;
  localparam int MIN_FRAME     = 8;
  localparam int MIN_REQ       = 12;
  localparam int READ_ECHO_END = 7;

  localparam logic [BYTE_W-1:0] WRITE_LEN_BYTE = 8'd6;
  localparam logic [BYTE_W-1:0] READ_LEN_EXTRA = 8'd3;

endpackage

### rtl/core/mbts_req_if.sv
// Request channel of the Modbus TCP register server: valid/ready plus the
// request fields. Depends on mbts_pkg.
interface mbts_req_if;
  import mbts_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [BYTE_W-1:0]   frame_byte;
  logic                frame_end;
  logic [INDEX_W-1:0]  table_index;
  logic [VALUE_W-1:0]  table_value;

  modport source(output valid, opcode, frame_byte, frame_end, table_index, table_value,
                 input ready);
  modport sink(input valid, opcode, frame_byte, frame_end, table_index, table_value,
               output ready);
endinterface

### rtl/core/mbts_rsp_if.sv
// Result channel of the Modbus TCP register server: valid/ready plus the
// result fields. Depends on mbts_pkg.
interface mbts_rsp_if;
  import mbts_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  result_kind;
  logic [BYTE_W-1:0]  reply_byte;
  logic               reply_end;
  logic [VALUE_W-1:0] read_value;

  modport source(output valid, result_kind, reply_byte, reply_end, read_value, input ready);
  modport sink(input valid, result_kind, reply_byte, reply_end, read_value, output ready);
endinterface

### rtl/core/modbus_tcp_register_server_unit.sv
// Modbus TCP register server top level: frame buffer, holding and input
// register tables and the request sequencer. Depends on mbts_pkg,
// mbts_req_if and mbts_rsp_if.
//
// Usage: requests enter on req, results leave on rsp (valid/ready each).
// Opcode 0 stores a frame byte; frame_end on it starts serving the frame.
// Opcodes 1 and 2 write the input or holding table, opcode 3 reads a
// holding register and returns one read-data result.
// A frame byte without frame_end and the set opcodes are served in idle.
// A read opcode reads the holding table, then returns its result. A frame end
// is decoded first (header bytes fetched one per cycle from the frame buffer),
// then the echoed bytes and the register words are sent; function 16 first
// stores its words. Frame buffer and table reads are registered.
// req.ready is high only while no request is being served.
// Results go through one output register; when the receiver stalls, the
// sequencer waits with the next byte and holds its place.
// Reset (rst, synchronous) empties the frame buffer and clears both tables
// at once through per-entry valid bits; no clearing pass is needed.
module modbus_tcp_register_server_unit (
  input  logic            clk,
  input  logic            rst,
  mbts_req_if.sink        req,
  mbts_rsp_if.source      rsp
);
  import mbts_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK0 = 4'd1;
  localparam logic [3:0] S_FN   = 4'd2;
  localparam logic [3:0] S_HDR  = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_WRD  = 4'd5;
  localparam logic [3:0] S_WHI  = 4'd6;
  localparam logic [3:0] S_WLO  = 4'd7;
  localparam logic [3:0] S_ERD  = 4'd8;
  localparam logic [3:0] S_EOUT = 4'd9;
  localparam logic [3:0] S_CNT  = 4'd10;
  localparam logic [3:0] S_RRD  = 4'd11;
  localparam logic [3:0] S_RHI  = 4'd12;
  localparam logic [3:0] S_RLO  = 4'd13;
  localparam logic [3:0] S_REJ  = 4'd14;
  localparam logic [3:0] S_APP  = 4'd15;

  logic [3:0]         state, state_next;
  logic [FS_AW-1:0]   ptr, ptr_next;
  logic [CNT_W-1:0]   wcnt, wcnt_next;
  logic [31:0]        hdr, hdr_next;
  logic [BYTE_W-1:0]  fn, fn_next;
  logic [BYTE_W-1:0]  hi_byte, hi_next;
  logic [FC_W-1:0]    frame_count;
  logic               overflow_seen;
  logic               frame_clr;

  // frame buffer
  logic [BYTE_W-1:0]  frame_store [FRAME_BYTES];
  logic               fs_we, fs_re;
  logic [FS_AW-1:0]   fs_raddr;
  logic [BYTE_W-1:0]  fs_rdata;

  // register tables
  logic [VALUE_W-1:0] hold_mem [HOLDING_REGS];
  logic [VALUE_W-1:0] in_mem [INPUT_REGS];
  logic [HOLDING_REGS-1:0] hold_vld;
  logic [INPUT_REGS-1:0]   in_vld;
  logic               hw_en, iw_en, seq_hw, tbl_re;
  logic [H_AW-1:0]    hw_addr, seq_haddr, hold_raddr;
  logic [I_AW-1:0]    in_raddr, iw_addr;
  logic [VALUE_W-1:0] hw_data, seq_hdata;
  logic [VALUE_W-1:0] hold_q, in_q;
  logic               hold_vq, in_vq;
  logic [VALUE_W-1:0] hold_word, in_word, reg_word;

  // output register
  logic               rsp_valid, out_free;
  logic               emit, emit_end;
  logic [KIND_W-1:0]  emit_kind;
  logic [BYTE_W-1:0]  emit_byte;
  logic [VALUE_W-1:0] emit_val;

  logic               req_acc;
  logic [15:0]        start, num, alu_b;
  logic [16:0]        alu_sum, lim;
  logic [FC_W-1:0]    len16;
  logic               is_wr, fn16, chk_bad;
  logic [CNT_W-1:0]   wcnt_inc;

  assign req.ready = (state == S_IDLE);
  assign req_acc   = req.valid && req.ready;
  assign out_free  = !rsp_valid || rsp.ready;
  assign rsp.valid = rsp_valid;

  assign start  = hdr[31:16];
  assign num    = hdr[15:0];
  assign is_wr  = (fn == FN_WRITE_ONE) || (fn == FN_WRITE_MULTI);
  assign fn16   = (fn == FN_WRITE_MULTI);

  // shared adder: range check in S_CHK, register address start+i elsewhere
  assign alu_b   = (state == S_CHK) ? num : 16'(wcnt);
  assign alu_sum = {1'b0, start} + {1'b0, alu_b};

  assign lim = ((fn == FN_READ_INPUT) ? 17'(INPUT_REGS) : 17'(HOLDING_REGS));
  // only meaningful once count is known to be within MAX_WORDS
  assign len16 = FC_W'(POS_DATA) + FC_W'({num[CNT_W-1:0], 1'b0});
  assign chk_bad = (fn == FN_WRITE_ONE) ? (start >= 16'(HOLDING_REGS))
                 : ((num > 16'(MAX_WORDS)) || (alu_sum > lim) ||
                    (fn16 && (frame_count < len16)));
  assign wcnt_inc = wcnt + 1'b1;

  assign hold_word = hold_vq ? hold_q : '0;
  assign in_word   = in_vq ? in_q : '0;
  assign reg_word  = (fn == FN_READ_INPUT) ? in_word : hold_word;

  assign fs_we = req_acc && (req.opcode == OP_FRAME_BYTE) &&
                 (frame_count < FC_W'(FRAME_BYTES));

  always_comb begin
    state_next = state;
    ptr_next   = ptr;
    wcnt_next  = wcnt;
    hdr_next   = hdr;
    fn_next    = fn;
    hi_next    = hi_byte;
    frame_clr  = 1'b0;
    fs_re      = 1'b0;
    fs_raddr   = ptr;
    tbl_re     = 1'b0;
    hold_raddr = alu_sum[H_AW-1:0];
    in_raddr   = alu_sum[I_AW-1:0];
    seq_hw     = 1'b0;
    seq_haddr  = alu_sum[H_AW-1:0];
    seq_hdata  = {hi_byte, fs_rdata};
    emit       = 1'b0;
    emit_kind  = KIND_REPLY;
    emit_byte  = '0;
    emit_end   = 1'b0;
    emit_val   = '0;
    unique case (state)
      S_IDLE: begin
        if (req_acc) begin
          if (req.opcode == OP_FRAME_BYTE && req.frame_end) begin
            state_next = S_CHK0;
          end else if (req.opcode == OP_READ_HOLD) begin
            tbl_re     = 1'b1;
            hold_raddr = H_AW'(req.table_index);
            state_next = S_APP;
          end
        end
      end
      S_CHK0: begin
        if (overflow_seen || frame_count < FC_W'(MIN_FRAME)) begin
          state_next = S_REJ;
        end else begin
          fs_re      = 1'b1;
          fs_raddr   = FS_AW'(POS_FN);
          state_next = S_FN;
        end
      end
      S_FN: begin
        fn_next = fs_rdata;
        if (fs_rdata != FN_READ_HOLD && fs_rdata != FN_READ_INPUT &&
            fs_rdata != FN_WRITE_ONE && fs_rdata != FN_WRITE_MULTI) begin
          // unknown function: drop the frame silently
          frame_clr  = 1'b1;
          state_next = S_IDLE;
        end else if (frame_count < FC_W'(MIN_REQ)) begin
          state_next = S_REJ;
        end else begin
          fs_re      = 1'b1;
          fs_raddr   = FS_AW'(POS_START);
          ptr_next   = FS_AW'(POS_START);
          state_next = S_HDR;
        end
      end
      S_HDR: begin
        hdr_next = {hdr[23:0], fs_rdata};
        if (ptr == FS_AW'(POS_HDR_LAST)) begin
          state_next = S_CHK;
        end else begin
          fs_re    = 1'b1;
          fs_raddr = ptr + 1'b1;
          ptr_next = ptr + 1'b1;
        end
      end
      S_CHK: begin
        wcnt_next = '0;
        if (chk_bad) begin
          state_next = S_REJ;
        end else if (fn == FN_WRITE_ONE) begin
          seq_hw     = 1'b1;
          seq_haddr  = start[H_AW-1:0];
          seq_hdata  = num;
          ptr_next   = '0;
          state_next = S_ERD;
        end else if (fn16 && num != 16'd0) begin
          ptr_next   = FS_AW'(POS_DATA);
          state_next = S_WRD;
        end else begin
          ptr_next   = '0;
          state_next = S_ERD;
        end
      end
      S_WRD: begin
        fs_re      = 1'b1;
        ptr_next   = ptr + 1'b1;
        state_next = S_WHI;
      end
      S_WHI: begin
        hi_next    = fs_rdata;
        fs_re      = 1'b1;
        ptr_next   = ptr + 1'b1;
        state_next = S_WLO;
      end
      S_WLO: begin
        seq_hw    = 1'b1;
        wcnt_next = wcnt_inc;
        if (wcnt_inc == num[CNT_W-1:0]) begin
          ptr_next   = '0;
          state_next = S_ERD;
        end else begin
          state_next = S_WRD;
        end
      end
      S_ERD: begin
        fs_re      = 1'b1;
        state_next = S_EOUT;
      end
      S_EOUT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_byte = fs_rdata;
          if (ptr == FS_AW'(POS_LEN)) begin
            emit_byte = is_wr ? WRITE_LEN_BYTE
                              : BYTE_W'({num[CNT_W-1:0], 1'b0}) + READ_LEN_EXTRA;
          end
          if (is_wr && ptr == FS_AW'(POS_HDR_LAST)) begin
            emit_end   = 1'b1;
            frame_clr  = 1'b1;
            state_next = S_IDLE;
          end else if (!is_wr && ptr == FS_AW'(READ_ECHO_END)) begin
            state_next = S_CNT;
          end else begin
            ptr_next   = ptr + 1'b1;
            state_next = S_ERD;
          end
        end
      end
      S_CNT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_byte = BYTE_W'({num[CNT_W-1:0], 1'b0});
          if (num == 16'd0) begin
            emit_end   = 1'b1;
            frame_clr  = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_RRD;
          end
        end
      end
      S_RRD: begin
        tbl_re     = 1'b1;
        state_next = S_RHI;
      end
      S_RHI: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_byte  = reg_word[15:8];
          state_next = S_RLO;
        end
      end
      S_RLO: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_byte = reg_word[7:0];
          wcnt_next = wcnt_inc;
          if (wcnt_inc == num[CNT_W-1:0]) begin
            emit_end   = 1'b1;
            frame_clr  = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_RRD;
          end
        end
      end
      S_REJ: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_kind  = KIND_REJECT;
          emit_end   = 1'b1;
          frame_clr  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_APP: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_kind  = KIND_READ;
          emit_end   = 1'b1;
          emit_val   = hold_word;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // table write ports: application side in idle, sequencer otherwise
  always_comb begin
    hw_en   = seq_hw;
    hw_addr = seq_haddr;
    hw_data = seq_hdata;
    iw_en   = 1'b0;
    iw_addr = I_AW'(req.table_index);
    if (req_acc && req.opcode == OP_SET_HOLD &&
        {1'b0, req.table_index} < (INDEX_W + 1)'(HOLDING_REGS)) begin
      hw_en   = 1'b1;
      hw_addr = H_AW'(req.table_index);
      hw_data = req.table_value;
    end
    if (req_acc && req.opcode == OP_SET_INPUT &&
        {1'b0, req.table_index} < (INDEX_W + 1)'(INPUT_REGS)) begin
      iw_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      frame_count   <= '0;
      overflow_seen <= 1'b0;
      rsp_valid     <= 1'b0;
      hold_vld      <= '0;
      in_vld        <= '0;
    end else begin
      state <= state_next;
      if (frame_clr) begin
        frame_count   <= '0;
        overflow_seen <= 1'b0;
      end else if (fs_we) begin
        frame_count <= frame_count + 1'b1;
      end else if (req_acc && req.opcode == OP_FRAME_BYTE) begin
        overflow_seen <= 1'b1;
      end
      if (emit && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if (hw_en) begin
        hold_vld[hw_addr] <= 1'b1;
      end
      if (iw_en) begin
        in_vld[iw_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr     <= ptr_next;
    wcnt    <= wcnt_next;
    hdr     <= hdr_next;
    fn      <= fn_next;
    hi_byte <= hi_next;
    if (emit && out_free) begin
      rsp.result_kind <= emit_kind;
      rsp.reply_byte  <= emit_byte;
      rsp.reply_end   <= emit_end;
      rsp.read_value  <= emit_val;
    end
  end

  always_ff @(posedge clk) begin
    if (fs_we) begin
      frame_store[frame_count[FS_AW-1:0]] <= req.frame_byte;
    end
    if (fs_re) begin
      fs_rdata <= frame_store[fs_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (hw_en) begin
      hold_mem[hw_addr] <= hw_data;
    end
    if (iw_en) begin
      in_mem[iw_addr] <= req.table_value;
    end
    if (tbl_re) begin
      hold_q  <= hold_mem[hold_raddr];
      hold_vq <= hold_vld[hold_raddr];
      in_q    <= in_mem[in_raddr];
      in_vq   <= in_vld[in_raddr];
    end
  end

`ifndef SYNTHESIS
  a_overflow_flag: assert property (@(posedge clk) disable iff (rst)
    (req_acc && req.opcode == OP_FRAME_BYTE && !req.frame_end &&
     frame_count == FC_W'(FRAME_BYTES)) |=> overflow_seen)
    else $error("dropped frame byte did not set overflow flag");

  a_reject_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_REJ && out_free) |=> (state == S_IDLE && frame_count == '0 &&
                                      !overflow_seen))
    else $error("frame not emptied after reject");

  a_hold_write_src: assert property (@(posedge clk) disable iff (rst)
    hw_en |-> (state != S_IDLE || (req.valid && req.opcode == OP_SET_HOLD)))
    else $error("holding table written without a source");

  a_more_results: assert property (@(posedge clk) disable iff (rst)
    (emit && out_free && !emit_end) |=> (state != S_IDLE))
    else $error("result sequence stopped before its final result");
`endif

endmodule
